FILE: rtl/rpd_pkg.sv
package rpd_pkg;

  // Field widths.
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned SIZE_W    = 9;
  localparam int unsigned CODE_W    = 7;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned PHASE_W   = 2;

  // Packed result word: 74 bits of fields, padded to whole bytes.
  localparam int unsigned OUT_TDATA_W = 80;
  localparam int unsigned OUT_TUSER_W = 3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_BUSY   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ACCEPT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

  // Byte positions within a packet.
  localparam logic [POS_W-1:0] POS_SEC_HIGH  = 9'd3;
  localparam logic [POS_W-1:0] POS_SEC_LOW   = 9'd4;
  localparam logic [POS_W-1:0] POS_TYPE      = 9'd5;
  localparam logic [POS_W-1:0] POS_SRC_HIGH  = 9'd6;
  localparam logic [POS_W-1:0] POS_SRC_LOW   = 9'd7;
  localparam logic [POS_W-1:0] POS_VERSION   = 9'd8;
  localparam logic [POS_W-1:0] POS_REC_FIRST = 9'd9;

  // A packet that passes the security check never ends before this count.
  localparam logic [POS_W-1:0] MIN_END_COUNT = 9'd5;

  // Record triple phases.
  localparam logic [PHASE_W-1:0] PH_ID      = 2'd0;
  localparam logic [PHASE_W-1:0] PH_VAL_HI  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_VAL_LO  = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SIZE_W-1:0] size;
  } sec_fields_t;

  // Even bits of the security word form the code; odd bits 1..13 and then
  // bits 14 and 15 form the size.
  function automatic sec_fields_t sec_decode(input logic [15:0] word);
    sec_fields_t f;
    for (int k = 0; k < 7; k++) begin
      f.code[k] = word[2*k];
      f.size[k] = word[2*k+1];
    end
    f.size[7] = word[14];
    f.size[8] = word[15];
    return f;
  endfunction

endpackage

FILE: rtl/radio_packet_receive_deframer_core.sv
// Receive deframer for radio packets.
//
// Bytes enter one word at a time on the s_ channel. Every accepted byte
// produces exactly one result word on the m_ channel, carrying the byte's
// position, the decoded packet size, the captured header fields and, when
// an id/value triple completes, a record. m_tlast marks the byte that ends
// a packet; m_tuser carries the status and the record flag.
//
// The result of a byte is registered: it is valid after the edge at which
// the byte is accepted. Throughput is one byte per cycle while results are
// taken, set by the single register stage that holds the result. A new byte
// is taken while a result waits, as long as the receiver takes that result
// in the same cycle. When the receiver stalls, the result is held and
// s_tready drops until it is taken, so no byte is lost or repeated.
//
// Reset (rst, synchronous, active high) clears the packet state, the security
// code register and the output valid. The user must write the security code
// through cfg_we/cfg_wdata while the block is idle; it is not enforced.
module radio_packet_receive_deframer_core (
  input  logic                             clk,
  input  logic                             rst,
  // Configuration: security code.
  input  logic                             cfg_we,
  input  logic [rpd_pkg::CODE_W-1:0]       cfg_wdata,
  // Input bytes. tdata: data_byte[7:0].
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [rpd_pkg::BYTE_W-1:0]       s_tdata,
  // Results. tdata: byte_index[8:0], packet_size[17:9], packet_type[25:18],
  // source_addr[41:26], format_version[49:42], record_id[57:50],
  // record_value[73:58], zero pad [79:74].
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [rpd_pkg::OUT_TDATA_W-1:0]  m_tdata,
  // tuser: status[1:0], record_valid[2]. tlast: packet_end.
  output logic [rpd_pkg::OUT_TUSER_W-1:0]  m_tuser,
  output logic                             m_tlast
);

  // Configuration register.
  logic [rpd_pkg::CODE_W-1:0] secure_code;

  // Packet state.
  logic [rpd_pkg::POS_W-1:0]   byte_count;
  logic [rpd_pkg::SIZE_W-1:0]  decoded_size;
  logic [rpd_pkg::BYTE_W-1:0]  sec_high;
  logic [rpd_pkg::BYTE_W-1:0]  type_hold;
  logic [rpd_pkg::ADDR_W-1:0]  source_hold;
  logic [rpd_pkg::BYTE_W-1:0]  version_hold;
  logic [rpd_pkg::BYTE_W-1:0]  rec_id_hold;
  logic [rpd_pkg::BYTE_W-1:0]  rec_value_high;
  // Position within the current id/value triple; replaces (pos - 9) mod 3.
  logic [rpd_pkg::PHASE_W-1:0] rec_phase;

  logic [rpd_pkg::POS_W-1:0]   byte_count_next;
  logic [rpd_pkg::SIZE_W-1:0]  decoded_size_next;
  logic [rpd_pkg::BYTE_W-1:0]  sec_high_next;
  logic [rpd_pkg::BYTE_W-1:0]  type_hold_next;
  logic [rpd_pkg::ADDR_W-1:0]  source_hold_next;
  logic [rpd_pkg::BYTE_W-1:0]  version_hold_next;
  logic [rpd_pkg::BYTE_W-1:0]  rec_id_hold_next;
  logic [rpd_pkg::BYTE_W-1:0]  rec_value_high_next;
  logic [rpd_pkg::PHASE_W-1:0] rec_phase_next;

  logic                        ended;
  logic [rpd_pkg::STATUS_W-1:0] status_next;
  logic                        rec_valid_next;
  logic [rpd_pkg::BYTE_W-1:0]  rec_id_next;
  logic [rpd_pkg::VALUE_W-1:0] rec_val_next;
  rpd_pkg::sec_fields_t        sec;

  logic s_accept;
  logic m_accept;

  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign m_accept = m_tvalid && m_tready;

  assign sec = rpd_pkg::sec_decode({sec_high, s_tdata});

  always_comb begin
    sec_high_next       = sec_high;
    type_hold_next      = type_hold;
    source_hold_next    = source_hold;
    version_hold_next   = version_hold;
    rec_id_hold_next    = rec_id_hold;
    rec_value_high_next = rec_value_high;
    rec_phase_next      = rec_phase;
    decoded_size_next   = decoded_size;
    rec_valid_next      = 1'b0;
    rec_id_next         = '0;
    rec_val_next        = '0;
    ended               = 1'b0;
    status_next         = rpd_pkg::STAT_BUSY;

    // Header capture by position.
    if (byte_count == rpd_pkg::POS_SEC_HIGH) begin
      sec_high_next = s_tdata;
    end
    if (byte_count == rpd_pkg::POS_TYPE) begin
      type_hold_next = s_tdata;
    end
    if (byte_count == rpd_pkg::POS_SRC_HIGH) begin
      source_hold_next = {s_tdata, source_hold[7:0]};
    end
    if (byte_count == rpd_pkg::POS_SRC_LOW) begin
      source_hold_next = {source_hold[15:8], s_tdata};
    end
    if (byte_count == rpd_pkg::POS_VERSION) begin
      version_hold_next = s_tdata;
    end

    // Record triples from position 9 on.
    if (byte_count >= rpd_pkg::POS_REC_FIRST) begin
      unique case (rec_phase)
        rpd_pkg::PH_ID: begin
          rec_id_hold_next = s_tdata;
          rec_phase_next   = rpd_pkg::PH_VAL_HI;
        end
        rpd_pkg::PH_VAL_HI: begin
          rec_value_high_next = s_tdata;
          rec_phase_next      = rpd_pkg::PH_VAL_LO;
        end
        default: begin
          rec_valid_next = 1'b1;
          rec_id_next    = rec_id_hold;
          rec_val_next   = {rec_value_high, s_tdata};
          rec_phase_next = rpd_pkg::PH_ID;
        end
      endcase
    end

    byte_count_next = byte_count + 9'd1;

    // The low security byte checks the code and loads the size; later
    // bytes end the packet once the count reaches that size.
    if (byte_count == rpd_pkg::POS_SEC_LOW) begin
      if (sec.code != secure_code) begin
        ended       = 1'b1;
        status_next = rpd_pkg::STAT_REJECT;
      end else begin
        decoded_size_next = sec.size;
      end
    end else if (byte_count_next > rpd_pkg::MIN_END_COUNT &&
                 byte_count_next >= decoded_size) begin
      ended       = 1'b1;
      status_next = rpd_pkg::STAT_ACCEPT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      secure_code <= '0;
    end else if (cfg_we) begin
      secure_code <= cfg_wdata;
    end
  end

  // Packet state: cleared at reset and after the ending byte.
  always_ff @(posedge clk) begin
    if (rst || (s_accept && ended)) begin
      byte_count     <= '0;
      decoded_size   <= '0;
      sec_high       <= '0;
      type_hold      <= '0;
      source_hold    <= '0;
      version_hold   <= '0;
      rec_id_hold    <= '0;
      rec_value_high <= '0;
      rec_phase      <= rpd_pkg::PH_ID;
    end else if (s_accept) begin
      byte_count     <= byte_count_next;
      decoded_size   <= decoded_size_next;
      sec_high       <= sec_high_next;
      type_hold      <= type_hold_next;
      source_hold    <= source_hold_next;
      version_hold   <= version_hold_next;
      rec_id_hold    <= rec_id_hold_next;
      rec_value_high <= rec_value_high_next;
      rec_phase      <= rec_phase_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_accept) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tlast <= ended;
      m_tuser <= {rec_valid_next, status_next};
      m_tdata <= {6'd0, rec_val_next, rec_id_next, version_hold_next,
                  source_hold_next, type_hold_next, decoded_size_next, byte_count};
    end
  end

  // The end mark and the status always agree.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser[1:0] != rpd_pkg::STAT_BUSY)))
    else $error("packet end and status disagree");

  // An ending byte restarts the count at position zero.
  assert property (@(posedge clk) disable iff (rst)
    (s_accept && ended) |=> (byte_count == '0 && rec_phase == rpd_pkg::PH_ID))
    else $error("packet state not cleared after end");

  // A record can never complete before position 11, the third byte of the first triple.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |-> (m_tdata[8:0] >= 9'd11))
    else $error("record emitted too early");

  // Rejection can only come from the low security byte.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1:0] == rpd_pkg::STAT_REJECT) |->
      (m_tdata[8:0] == rpd_pkg::POS_SEC_LOW))
    else $error("reject outside security byte");

endmodule

FILE: dv/radio_packet_receive_deframer_core_tb.sv
`timescale 1ns / 1ps

module radio_packet_receive_deframer_core_tb;
  import rpd_pkg::*;

  // One result word, split into its fields.
  typedef struct packed {
    logic                 last;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     index;
    logic [SIZE_W-1:0]    size;
    logic [BYTE_W-1:0]    ptype;
    logic [ADDR_W-1:0]    src;
    logic [BYTE_W-1:0]    version;
    logic                 rec_valid;
    logic [BYTE_W-1:0]    rec_id;
    logic [VALUE_W-1:0]   rec_value;
  } result_t;

  // One stimulus byte. When pinned is set, the end flag, status and index
  // of its result are typed in here instead of taken from the predictor.
  typedef struct packed {
    logic [BYTE_W-1:0]    b;
    logic                 pinned;
    logic                 last;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     index;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_we = 1'b0;
  logic [CODE_W-1:0]       cfg_wdata = '0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [BYTE_W-1:0]       s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic [OUT_TUSER_W-1:0]  m_tuser;
  logic                    m_tlast;

  radio_packet_receive_deframer_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor copy of the security code and of the packet state.
  logic [CODE_W-1:0]   code_cfg = '0;
  logic [POS_W-1:0]    count_q = '0;
  logic [SIZE_W-1:0]   size_q = '0;
  logic [BYTE_W-1:0]   sec_high_q = '0;
  logic [BYTE_W-1:0]   type_q = '0;
  logic [ADDR_W-1:0]   source_q = '0;
  logic [BYTE_W-1:0]   version_q = '0;
  logic [BYTE_W-1:0]   rec_id_q = '0;
  logic [BYTE_W-1:0]   rec_hi_q = '0;

  result_t  due_words[$];
  row_t     sent_rows[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;

  // Directed bytes. The first packet runs right after reset with the reset
  // code of zero and a decoded size of zero, so it ends on the earliest
  // allowed byte. The second carries code 1 and is rejected on its fifth
  // byte. The third has size 15 and carries two id/value records.
  row_t script [0:25] = '{
    '{8'hFF, 1'b1, 1'b0, STAT_BUSY,   9'd0},
    '{8'h00, 1'b1, 1'b0, STAT_BUSY,   9'd1},
    '{8'hAA, 1'b1, 1'b0, STAT_BUSY,   9'd2},
    '{8'h00, 1'b1, 1'b0, STAT_BUSY,   9'd3},
    '{8'h00, 1'b1, 1'b0, STAT_BUSY,   9'd4},
    '{8'hFF, 1'b1, 1'b1, STAT_ACCEPT, 9'd5},
    '{8'h12, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h34, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h56, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h80, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h01, 1'b1, 1'b1, STAT_REJECT, 9'd4},
    '{8'h00, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h00, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h00, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h00, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'hAA, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h5A, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'hFF, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h01, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h7E, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h11, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'hFE, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h80, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h22, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'h00, 1'b0, 1'b0, STAT_BUSY,   9'd0},
    '{8'hFF, 1'b1, 1'b1, STAT_ACCEPT, 9'd14}
  };

  // Works out the result of one byte and advances the packet state.
  function automatic result_t deframe_byte(input logic [BYTE_W-1:0] b);
    result_t            r;
    logic [POS_W-1:0]   pos;
    logic [POS_W-1:0]   cnt;
    logic [15:0]        word;
    logic [CODE_W-1:0]  code;
    logic [SIZE_W-1:0]  sz;
    int                 phase;
    r = '0;
    pos = count_q;
    case (pos)
      POS_SEC_HIGH: sec_high_q = b;
      POS_TYPE:     type_q = b;
      POS_SRC_HIGH: source_q[15:8] = b;
      POS_SRC_LOW:  source_q[7:0] = b;
      POS_VERSION:  version_q = b;
      default: ;
    endcase
    if (pos >= POS_REC_FIRST) begin
      phase = (int'(pos) - int'(POS_REC_FIRST)) % 3;
      if (phase == int'(PH_ID)) begin
        rec_id_q = b;
      end else if (phase == int'(PH_VAL_HI)) begin
        rec_hi_q = b;
      end else begin
        r.rec_valid = 1'b1;
        r.rec_id = rec_id_q;
        r.rec_value = {rec_hi_q, b};
      end
    end
    cnt = pos + 9'd1;
    count_q = cnt;
    r.status = STAT_BUSY;
    if (cnt == MIN_END_COUNT) begin
      // The low byte of the security word has just arrived.
      word = {sec_high_q, b};
      for (int k = 0; k < 7; k++) begin
        code[k] = word[2*k];
        sz[k] = word[2*k+1];
      end
      sz[7] = word[14];
      sz[8] = word[15];
      if (code != code_cfg) begin
        r.last = 1'b1;
        r.status = STAT_REJECT;
      end else begin
        size_q = sz;
      end
    end else if (cnt > MIN_END_COUNT && cnt >= size_q) begin
      r.last = 1'b1;
      r.status = STAT_ACCEPT;
    end
    r.index = pos;
    r.size = size_q;
    r.ptype = type_q;
    r.src = source_q;
    r.version = version_q;
    if (r.last) begin
      {count_q, size_q, sec_high_q, type_q, source_q, version_q, rec_id_q, rec_hi_q} = '0;
    end
    return r;
  endfunction

  // Builds the interleaved security word for a code and a size.
  function automatic logic [15:0] sec_word(input logic [CODE_W-1:0] code,
                                           input logic [SIZE_W-1:0] sz);
    logic [15:0] w;
    for (int k = 0; k < 7; k++) begin
      w[2*k] = code[k];
      w[2*k+1] = sz[k];
    end
    w[14] = sz[7];
    w[15] = sz[8];
    return w;
  endfunction

  function automatic row_t unpinned(input logic [BYTE_W-1:0] b);
    row_t t;
    t = '0;
    t.b = b;
    return t;
  endfunction

  task automatic report_if_off(input string field, input logic [15:0] got,
                               input logic [15:0] want, input logic [POS_W-1:0] pos);
    if (got !== want) begin
      mismatches++;
      $display("mismatch in %s at byte %0d: got %h, expected %h", field, pos, got, want);
    end
  endtask

  // Sends one byte, with a random gap in front of it unless the quiet
  // stretch is on. Returns at the edge where the word is taken.
  task automatic send_word(input row_t row);
    while (!quiet && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    sent_rows.push_back(row);
    s_tvalid <= 1'b1;
    s_tdata <= row.b;
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds the sender back until every expected word has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (due_words.size() != 0 || sent_rows.size() != 0);
  endtask

  task automatic set_code(input logic [CODE_W-1:0] v);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    code_cfg = v;
  endtask

  // Sends a whole packet with the given code and size. A packet whose code
  // does not match ends on its fifth byte; one that matches runs to the
  // decoded size, but never ends before its sixth byte.
  task automatic send_packet(input logic [CODE_W-1:0] code, input logic [SIZE_W-1:0] sz,
                             output int n);
    logic [15:0] w;
    int          len;
    w = sec_word(code, sz);
    for (int i = 0; i < 3; i++)
      send_word(unpinned(8'($urandom_range(255))));
    send_word(unpinned(w[15:8]));
    send_word(unpinned(w[7:0]));
    if (code != code_cfg)
      len = 5;
    else
      len = (sz <= 6) ? 6 : int'(sz);
    for (int i = 5; i < len; i++)
      send_word(unpinned(8'($urandom_range(255))));
    n = len;
  endtask

  // Receiver: stalls with a probability of about 27 percent outside the quiet stretch.
  always @(posedge clk)
    m_tready <= quiet || ($urandom_range(99) >= 27);

  // Scoreboard: checks each result word against the oldest expectation, then
  // predicts the result of any byte taken at this edge.
  always @(posedge clk) begin : scoreboard
    result_t want;
    row_t    tag;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (due_words.size() == 0) begin
          report_if_off("unexpected word", 16'd1, 16'd0, m_tdata[8:0]);
        end else begin
          want = due_words.pop_front();
          report_if_off("packet_end",     16'(m_tlast),        16'(want.last),
                        want.index);
          report_if_off("status",         16'(m_tuser[1:0]),   16'(want.status),
                        want.index);
          report_if_off("record_valid",   16'(m_tuser[2]),     16'(want.rec_valid),
                        want.index);
          report_if_off("byte_index",     16'(m_tdata[8:0]),   16'(want.index),
                        want.index);
          report_if_off("packet_size",    16'(m_tdata[17:9]),  16'(want.size),
                        want.index);
          report_if_off("packet_type",    16'(m_tdata[25:18]), 16'(want.ptype),
                        want.index);
          report_if_off("source_addr",    m_tdata[41:26],      want.src,
                        want.index);
          report_if_off("format_version", 16'(m_tdata[49:42]), 16'(want.version),
                        want.index);
          report_if_off("record_id",      16'(m_tdata[57:50]), 16'(want.rec_id),
                        want.index);
          report_if_off("record_value",   m_tdata[73:58],      want.rec_value,
                        want.index);
          report_if_off("tdata padding",  16'(m_tdata[79:74]), 16'd0,
                        want.index);
        end
      end
      if (s_tvalid && s_tready) begin
        tag = sent_rows.pop_front();
        want = deframe_byte(s_tdata);
        if (tag.pinned) begin
          want.last = tag.last;
          want.status = tag.status;
          want.index = tag.index;
        end
        due_words.push_back(want);
      end
    end
  end

  initial begin : stimulus
    logic [CODE_W-1:0]  phase_code [0:4];
    logic [SIZE_W-1:0]  sz;
    int                 budget;
    int                 n;
    int                 pick;
    int                 guard;
    phase_code[0] = 7'h7F;
    phase_code[1] = 7'($urandom_range(1, 126));
    phase_code[2] = 7'h00;
    phase_code[3] = 7'($urandom_range(127));
    phase_code[4] = 7'h2A;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed bytes run with the security code left at its reset value.
    foreach (script[i])
      send_word(script[i]);

    for (int p = 0; p < 5; p++) begin
      set_code(phase_code[p]);
      quiet = (p == 2);
      // One packet of the largest size, sent while the code is all ones so
      // that the security word is all ones too.
      if (p == 0)
        send_packet(7'h7F, 9'h1FF, n);
      budget = 0;
      while (budget < 16) begin
        sz = ($urandom_range(19) == 0) ? 9'($urandom_range(41, 160))
                                       : 9'($urandom_range(40));
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_packet(code_cfg, sz, n);
        end else if (pick < 90) begin
          send_packet(code_cfg ^ 7'($urandom_range(1, 127)), sz, n);
        end else begin
          // Noise: a few bytes of no particular shape.
          n = $urandom_range(1, 12);
          for (int i = 0; i < n; i++)
            send_word(unpinned(8'($urandom_range(255))));
        end
        budget += n;
        if ($urandom_range(14) == 0)
          drain_results();
      end
    end

    s_tvalid <= 1'b0;
    guard = 0;
    while (due_words.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    if (due_words.size() != 0)
      report_if_off("words never produced", 16'(due_words.size()), 16'd0, 9'd0);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
